/* design/otq_pkg.sv */
// Package for the ordered timer queue: command and status codes, sizes, states.
// No dependencies.
`default_nettype none
package otq_pkg;
   localparam int NUM_SLOTS = 16;
   localparam int SLOT_W = 4;
   localparam logic [31:0] WINDOW_RESET = 32'd3600000;

   typedef enum logic [2:0] {
      CMD_ADD = 3'd0, CMD_CANCEL = 3'd1, CMD_REFRESH = 3'd2,
      CMD_RESET = 3'd3, CMD_EXPIRE = 3'd4, CMD_QUERY = 3'd5,
      CMD_BAD6 = 3'd6, CMD_BAD7 = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0, ST_INACTIVE = 2'd1, ST_FULL = 2'd2, ST_NONE = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_DECIDE, S_EMIT, S_WAIT
   } state_type;
endpackage
`default_nettype wire

/* design/otq_scan.sv */
// Shared compare unit: walks the slots one per cycle while step is high and keeps the earliest
// candidate by deadline, ties to the lower slot. Uses otq_pkg.
`default_nettype none
module otq_scan import otq_pkg::*; (
   input  wire logic              clock,
   input  wire logic              start,
   input  wire logic              step,
   input  wire logic [SLOT_W-1:0] idx,
   input  wire logic              cand,
   input  wire logic [63:0]       dl,
   output logic                   found,
   output logic [SLOT_W-1:0]      best,
   output logic [63:0]            best_dl
);
   logic              found_ff;
   logic [SLOT_W-1:0] best_ff;
   logic [63:0]       dl_ff;
   logic              take;

   // strict less keeps the lower slot on ties since slots go upwards
   assign take = cand && (!found_ff || start || dl < dl_ff);

   always_ff @(posedge clock) begin
      if (start) begin
         found_ff <= 1'b0;
      end else if (step && take) begin
         found_ff <= 1'b1;
         best_ff  <= idx;
         dl_ff    <= dl;
      end
   end
   assign found = found_ff;
   assign best = best_ff;
   assign best_dl = dl_ff;
endmodule
`default_nettype wire

/* design/ordered_timer_queue_top.sv */
// Top level of the ordered timer queue: slot table, sequencer, result register.
// Depends on otq_pkg and otq_scan.
//
//  channel | dir | transfer when          | payload
//  req     | in  | req_tvalid&req_tready  | tdata: cmd,slot,period_ms,recurring,restart_now,now_ms
//  rsp     | out | rsp_tvalid&rsp_tready  | tdata: status,slot_out,remaining_ms,lead_flag; tlast
//  csr     | in  | csr_we                 | rollover_window_ms
//
// Add, reset and query take one compare pass over the 16 slots, one slot a cycle: the
// result loads after decode, scan and emit. Cancel, refresh and the short cases
// load it from decode, without a pass. Expire makes a pass for the due set, then one
// pass per expired timer, each of which loads one result, the last with tlast set.
// reset is synchronous; the table marks clear and the window returns to 3600000.
// A stalled result holds; the next pass or command waits until the result leaves.
`default_nettype none
module ordered_timer_queue_top import otq_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // cmd[2:0], slot[6:3], period_ms[38:7], recurring[39], restart_now[40],
   // now_ms[104:41], zero [111:105]
   input  wire logic [111:0] req_tdata,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // status[1:0], slot_out[5:2], remaining_ms[69:6], lead_flag[70], zero [71]
   output logic [71:0]       rsp_tdata,
   output logic              rsp_tlast,
   input  wire logic         csr_we,
   input  wire logic [31:0]  csr_wdata
);
   logic [63:0]          dl_ff [NUM_SLOTS];
   logic [31:0]          per_ff [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] rep_ff, act_ff, due_ff, due_in;
   logic                 notice_ff, notice_in;
   logic [63:0]          prev_ff, prev_in;
   logic [31:0]          win_ff;
   state_type            st_ff, st_in;
   cmd_type              cmd_ff;
   logic [SLOT_W-1:0]    slot_ff;
   logic [31:0]          p_ff;
   logic                 rec_ff, fnow_ff;
   logic [63:0]          now_ff;
   logic [SLOT_W:0]      idx_ff, idx_in;
   logic [1:0]           ost_ff, ost_in;
   logic [SLOT_W-1:0]    oslot_ff, oslot_in;
   logic [63:0]          orem_ff, orem_in;
   logic                 ofront_ff, ofront_in, olast_ff, olast_in;
   logic                 ovalid_ff, ovalid_in;
   logic                 front_pass_ff, front_pass_in;

   // single table write port
   logic              wr_dl_en, wr_per_en, wr_rep_en, wr_act_en, wr_act;
   logic [SLOT_W-1:0] wr_slot;
   logic [63:0]       wr_dl;

   logic              sc_start, sc_step, sc_cand, sc_found;
   logic [SLOT_W-1:0] sc_best, sc_idx;
   logic [63:0]       sc_dl, sc_best_dl;

   assign sc_idx = idx_ff[SLOT_W-1:0];
   assign sc_dl = dl_ff[sc_idx];
   assign sc_cand = (cmd_ff == CMD_EXPIRE && !front_pass_ff) ? due_ff[sc_idx]
                                                             : act_ff[sc_idx];
   assign sc_step = (st_ff == S_SCAN);
   assign sc_start = (st_ff == S_IDLE) || (st_ff == S_EMIT);

   otq_scan u_scan (
      .clock(clock), .start(sc_start), .step(sc_step), .idx(sc_idx),
      .cand(sc_cand), .dl(sc_dl), .found(sc_found), .best(sc_best),
      .best_dl(sc_best_dl)
   );

   assign req_tready = (st_ff == S_IDLE) && !ovalid_ff;
   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata = {1'b0, ofront_ff, orem_ff, oslot_ff, ost_ff};
   assign rsp_tlast = olast_ff;

   // lowest free slot
   logic              slot_live;
   logic [SLOT_W-1:0] free_slot;
   logic              has_free;
   assign slot_live = act_ff[slot_ff];
   always_comb begin
      free_slot = '0;
      has_free = 1'b0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (!act_ff[i]) begin
            free_slot = SLOT_W'(i);
            has_free = 1'b1;
         end
      end
   end

   // rollover test and last expired timer
   logic [63:0] roll_lim;
   logic        roll;
   logic        due_last;
   assign roll_lim = prev_ff - {32'd0, win_ff};
   assign roll = (now_ff < prev_ff) && (now_ff < roll_lim);
   assign due_last = (due_ff & ~(NUM_SLOTS'(1) << sc_best)) == '0;

   // sequencer: next state, result register and table writes
   always_comb begin
      st_in = st_ff;
      idx_in = idx_ff;
      front_pass_in = front_pass_ff;
      due_in = due_ff;
      notice_in = notice_ff;
      prev_in = prev_ff;
      ost_in = ost_ff;
      oslot_in = oslot_ff;
      orem_in = orem_ff;
      ofront_in = ofront_ff;
      olast_in = olast_ff;
      ovalid_in = ovalid_ff && !rsp_tready;
      wr_slot = slot_ff;
      wr_dl = '0;
      wr_dl_en = 1'b0;
      wr_per_en = 1'b0;
      wr_rep_en = 1'b0;
      wr_act_en = 1'b0;
      wr_act = 1'b0;
      case (st_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) st_in = S_DECIDE;
         end
         S_DECIDE: begin
            // apply the command, then, unless it finishes here, scan for the front or for due timers
            idx_in = '0;
            front_pass_in = 1'b1;
            st_in = S_SCAN;
            ost_in = ST_OK;
            oslot_in = slot_ff;
            orem_in = '0;
            ofront_in = 1'b0;
            olast_in = 1'b1;
            case (cmd_ff)
               CMD_ADD: begin
                  if (!has_free) begin
                     ost_in = ST_FULL; oslot_in = '0;
                     ovalid_in = 1'b1; st_in = S_IDLE;
                  end else begin
                     wr_slot = free_slot;
                     wr_dl = now_ff + {32'd0, p_ff};
                     wr_dl_en = 1'b1;
                     wr_per_en = 1'b1;
                     wr_rep_en = 1'b1;
                     wr_act_en = 1'b1;
                     wr_act = 1'b1;
                     oslot_in = free_slot;
                  end
               end
               CMD_CANCEL: begin
                  if (!slot_live) ost_in = ST_INACTIVE;
                  else wr_act_en = 1'b1;
                  ovalid_in = 1'b1; st_in = S_IDLE;
               end
               CMD_REFRESH: begin
                  if (!slot_live) ost_in = ST_INACTIVE;
                  else begin
                     wr_dl = now_ff + {32'd0, per_ff[slot_ff]};
                     wr_dl_en = 1'b1;
                  end
                  ovalid_in = 1'b1; st_in = S_IDLE;
               end
               CMD_RESET: begin
                  if (p_ff == per_ff[slot_ff] && !fnow_ff) begin
                     ovalid_in = 1'b1; st_in = S_IDLE;
                  end else if (!slot_live) begin
                     ost_in = ST_INACTIVE; ovalid_in = 1'b1; st_in = S_IDLE;
                  end else begin
                     wr_per_en = 1'b1;
                     wr_dl_en = 1'b1;
                     wr_dl = (fnow_ff ? now_ff
                        : dl_ff[slot_ff] - {32'd0, per_ff[slot_ff]}) + {32'd0, p_ff};
                  end
               end
               CMD_EXPIRE, CMD_QUERY: ;
               default: st_in = S_IDLE;
            endcase
         end
         S_SCAN: begin
            // the first pass also marks the due set, one slot a cycle
            idx_in = idx_ff + 1'b1;
            if (front_pass_ff) due_in[sc_idx] = act_ff[sc_idx] && (roll || sc_dl <= now_ff);
            if (idx_ff == (SLOT_W+1)'(NUM_SLOTS - 1)) st_in = S_EMIT;
         end
         S_EMIT: begin
            ost_in = ST_OK;
            orem_in = '0;
            ofront_in = 1'b0;
            olast_in = 1'b1;
            st_in = S_IDLE;
            case (cmd_ff)
               CMD_ADD, CMD_RESET: begin
                  if (sc_best == oslot_ff && !notice_ff) begin
                     ofront_in = 1'b1; notice_in = 1'b1;
                  end
                  ovalid_in = 1'b1;
               end
               CMD_QUERY: begin
                  notice_in = 1'b0;
                  oslot_in = '0;
                  orem_in = !sc_found ? '1
                     : (now_ff >= sc_best_dl) ? 64'd0 : sc_best_dl - now_ff;
                  ovalid_in = 1'b1;
               end
               default: begin
                  if (front_pass_ff) begin
                     // empty table leaves the previous time alone
                     if (!sc_found) begin
                        ost_in = ST_NONE; oslot_in = '0; ovalid_in = 1'b1;
                     end else begin
                        prev_in = now_ff;
                        if (due_ff == '0) begin
                           ost_in = ST_NONE; oslot_in = '0; ovalid_in = 1'b1;
                        end else begin
                           front_pass_in = 1'b0;
                           st_in = S_WAIT;
                        end
                     end
                  end else begin
                     // emit one expired timer, then look for the next
                     due_in[sc_best] = 1'b0;
                     wr_slot = sc_best;
                     if (rep_ff[sc_best]) begin
                        wr_dl = now_ff + {32'd0, per_ff[sc_best]};
                        wr_dl_en = 1'b1;
                     end else wr_act_en = 1'b1;
                     oslot_in = sc_best;
                     olast_in = due_last;
                     ovalid_in = 1'b1;
                     if (!due_last) st_in = S_WAIT;
                  end
               end
            endcase
         end
         S_WAIT: begin
            // hold the next pass until the result register is free
            if (!ovalid_ff || rsp_tready) begin
               idx_in = '0;
               st_in = S_SCAN;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   // state, table and other reset registers
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         act_ff <= '0;
         rep_ff <= '0;
         notice_ff <= 1'b0;
         prev_ff <= '0;
         win_ff <= WINDOW_RESET;
         ovalid_ff <= 1'b0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            dl_ff[i] <= '0;
            per_ff[i] <= '0;
         end
      end else begin
         st_ff <= st_in;
         notice_ff <= notice_in;
         prev_ff <= prev_in;
         ovalid_ff <= ovalid_in;
         if (csr_we) win_ff <= csr_wdata;
         if (wr_dl_en) dl_ff[wr_slot] <= wr_dl;
         if (wr_per_en) per_ff[wr_slot] <= p_ff;
         if (wr_rep_en) rep_ff[wr_slot] <= rec_ff;
         if (wr_act_en) act_ff[wr_slot] <= wr_act;
      end
   end

   // command capture and sequencer datapath
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      front_pass_ff <= front_pass_in;
      due_ff <= due_in;
      ost_ff <= ost_in;
      oslot_ff <= oslot_in;
      orem_ff <= orem_in;
      ofront_ff <= ofront_in;
      olast_ff <= olast_in;
      if (req_tvalid && req_tready) begin
         cmd_ff  <= cmd_type'(req_tdata[2:0]);
         slot_ff <= req_tdata[6:3];
         p_ff    <= req_tdata[38:7];
         rec_ff  <= req_tdata[39];
         fnow_ff <= req_tdata[40];
         now_ff  <= req_tdata[104:41];
      end
   end
endmodule
`default_nettype wire
